>>> rtl/ppw_pkg.sv
// Shared types, constants and saturation helpers for the prism pixel-to-wavelength block.
`timescale 1ns / 1ps

package ppw_pkg;

   localparam int unsigned WORD_W      = 48;
   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned HELIO_W     = 18;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned MAG_W       = WORD_W + 2;
   localparam int unsigned DIV_STEPS   = 48;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic signed [WORD_W-1:0] MAX_WAVELENGTH = 48'sd655360000;
   localparam logic signed [WORD_W-1:0] SCALE_RESET    = 48'sd65536;
   localparam logic [HELIO_W-1:0]       HELIO_UNITY    = 18'd65536;

   localparam logic signed [63:0] POS_LIMIT_64 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] NEG_LIMIT_64 = -64'sh0000_8000_0000_0000;
   localparam logic [MAG_W-1:0]   MAG_POS_CAP  = 50'h0_7FFF_FFFF_FFFF;
   localparam logic [MAG_W-1:0]   MAG_NEG_CAP  = 50'h0_8000_0000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PIXEL_SCALE        = 4'd0,
      REG_PIXEL_ORIGIN       = 4'd1,
      REG_BASE_WAVELENGTH    = 4'd2,
      REG_INVERSE_TERM_ONE   = 4'd3,
      REG_INVERSE_TERM_TWO   = 4'd4,
      REG_INVERSE_TERM_THREE = 4'd5,
      REG_INVERSE_TERM_FOUR  = 4'd6,
      REG_HELIO_FACTOR       = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pixel_scale;
      logic signed [WORD_W-1:0] pixel_origin;
      logic signed [WORD_W-1:0] base_wavelength;
      logic signed [WORD_W-1:0] inverse_term_one;
      logic signed [WORD_W-1:0] inverse_term_two;
      logic signed [WORD_W-1:0] inverse_term_three;
      logic signed [WORD_W-1:0] inverse_term_four;
      logic [HELIO_W-1:0]       helio_factor;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIVS,
      ST_DIVW,
      ST_ADD,
      ST_FINAL,
      ST_HELIO,
      ST_HSAT,
      ST_OUT
   } state_type;

   // Clamp a wide signed value into 48 bits signed.
   function automatic logic signed [WORD_W-1:0] sat48(input logic signed [63:0] v);
      if (v > POS_LIMIT_64) begin
         return POS_LIMIT_64[WORD_W-1:0];
      end else if (v < NEG_LIMIT_64) begin
         return NEG_LIMIT_64[WORD_W-1:0];
      end
      return v[WORD_W-1:0];
   endfunction

   // Apply a sign to a magnitude, saturating to 48 bits signed.
   function automatic logic signed [WORD_W-1:0] mag_to_signed(input logic [MAG_W-1:0] m,
                                                              input logic neg);
      logic [MAG_W-1:0] capped;
      if (neg) begin
         capped = (m > MAG_NEG_CAP) ? MAG_NEG_CAP : m;
         return $signed(48'd0 - capped[WORD_W-1:0]);
      end
      capped = (m > MAG_POS_CAP) ? MAG_POS_CAP : m;
      return $signed(capped[WORD_W-1:0]);
   endfunction

endpackage

>>> rtl/ppw_csr.sv
// Configuration register file for the prism pixel-to-wavelength block.
`timescale 1ns / 1ps

module ppw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppw_pkg::WORD_W-1:0]          csr_data,
   output ppw_pkg::cfg_type                    cfg
);

   ppw_pkg::cfg_type cfg_ff;
   ppw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ppw_pkg::csr_index_type'(csr_index))
            ppw_pkg::REG_PIXEL_SCALE:        cfg_in.pixel_scale        = $signed(csr_data);
            ppw_pkg::REG_PIXEL_ORIGIN:       cfg_in.pixel_origin       = $signed(csr_data);
            ppw_pkg::REG_BASE_WAVELENGTH:    cfg_in.base_wavelength    = $signed(csr_data);
            ppw_pkg::REG_INVERSE_TERM_ONE:   cfg_in.inverse_term_one   = $signed(csr_data);
            ppw_pkg::REG_INVERSE_TERM_TWO:   cfg_in.inverse_term_two   = $signed(csr_data);
            ppw_pkg::REG_INVERSE_TERM_THREE: cfg_in.inverse_term_three = $signed(csr_data);
            ppw_pkg::REG_INVERSE_TERM_FOUR:  cfg_in.inverse_term_four  = $signed(csr_data);
            ppw_pkg::REG_HELIO_FACTOR:
               cfg_in.helio_factor = csr_data[ppw_pkg::HELIO_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_scale        <= ppw_pkg::SCALE_RESET;
         cfg_ff.pixel_origin       <= '0;
         cfg_ff.base_wavelength    <= '0;
         cfg_ff.inverse_term_one   <= '0;
         cfg_ff.inverse_term_two   <= '0;
         cfg_ff.inverse_term_three <= '0;
         cfg_ff.inverse_term_four  <= '0;
         cfg_ff.helio_factor       <= ppw_pkg::HELIO_UNITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/ppw_div.sv
// Shared radix-2 restoring divider computing (a * 2^16) / x, saturated to 48 bits signed.
`timescale 1ns / 1ps

module ppw_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ppw_pkg::WORD_W-1:0]   dividend,
   input  logic signed [ppw_pkg::WORD_W-1:0]   divisor,
   output logic signed [ppw_pkg::WORD_W-1:0]   quotient,
   output ppw_pkg::div_status_type             status
);

   logic [ppw_pkg::WORD_W-1:0]    a_mag;
   logic [ppw_pkg::WORD_W-1:0]    d_mag;
   logic                          ovf_now;
   logic [ppw_pkg::WORD_W:0]      trial;
   logic [ppw_pkg::WORD_W:0]      diff;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ppw_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ppw_pkg::WORD_W-1:0]    rem_ff, rem_in;
   logic [ppw_pkg::WORD_W-1:0]    low_ff, low_in;
   logic [ppw_pkg::WORD_W-1:0]    quo_ff, quo_in;
   logic [ppw_pkg::WORD_W-1:0]    dmag_ff, dmag_in;
   logic                          neg_ff, neg_in;
   logic                          ovf_ff, ovf_in;

   assign a_mag = dividend[ppw_pkg::WORD_W-1] ? 48'd0 - dividend : dividend;
   assign d_mag = divisor[ppw_pkg::WORD_W-1]  ? 48'd0 - divisor  : divisor;
   // quotient reaches 2^48 exactly when |a| >= |x| * 2^32
   assign ovf_now = {32'd0, a_mag} >= {d_mag, 32'd0};

   assign trial = {rem_ff, low_ff[ppw_pkg::WORD_W-1]};
   assign diff  = trial - {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         rem_in  = {32'd0, a_mag[ppw_pkg::WORD_W-1:32]};
         low_in  = {a_mag[31:0], 16'd0};
         quo_in  = '0;
         cnt_in  = '0;
         dmag_in = d_mag;
         neg_in  = dividend[ppw_pkg::WORD_W-1] ^ divisor[ppw_pkg::WORD_W-1];
         ovf_in  = ovf_now;
         busy_in = !ovf_now;
         done_in = ovf_now;
      end else if (busy_ff) begin
         rem_in = diff[ppw_pkg::WORD_W] ? trial[ppw_pkg::WORD_W-1:0]
                                        : diff[ppw_pkg::WORD_W-1:0];
         quo_in = {quo_ff[ppw_pkg::WORD_W-2:0], !diff[ppw_pkg::WORD_W]};
         low_in = {low_ff[ppw_pkg::WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ppw_pkg::DIV_CNT_W'(ppw_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

   assign quotient = ovf_ff ? ppw_pkg::mag_to_signed({ppw_pkg::MAG_W{1'b1}}, neg_ff)
                            : ppw_pkg::mag_to_signed({2'b00, quo_ff}, neg_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/prism_pixel_to_wavelength.sv
// Top level: sequencer and datapath of the prism pixel-to-wavelength evaluator.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   req      | req_valid / req_stall  | req_pixel_index[11:0], req_row_end
//   rsp      | rsp_valid / rsp_stall  | rsp_wavelength[47:0] s, rsp_defect_flag, rsp_row_last
//   csr      | csr_valid / csr_ready  | csr_index[3:0], csr_data[47:0]
//
// A normal pixel runs the shared one-bit-per-cycle divider four times, once per
// Horner step; a division whose quotient saturates finishes at start, without the
// bit steps. A zero divisor skips the divisions and goes on to the heliocentric
// scaling and the output register. A pixel of a latched row goes from accept
// straight to the output register stage.
// One pixel is in work at a time; req_stall is high from accept until the result
// is moved into the output register, which holds it while rsp_stall is high.
// Synchronous active-high reset clears the sequencer, the row stop latch, the
// output valid and the configuration registers to their defaults.
`timescale 1ns / 1ps

module prism_pixel_to_wavelength (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ppw_pkg::INDEX_W-1:0]         req_pixel_index,
   input  logic                                req_row_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ppw_pkg::WORD_W-1:0]   rsp_wavelength,
   output logic                                rsp_defect_flag,
   output logic                                rsp_row_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppw_pkg::WORD_W-1:0]          csr_data
);

   ppw_pkg::cfg_type                  cfg;
   ppw_pkg::div_status_type           div_status;
   logic signed [ppw_pkg::WORD_W-1:0] div_q;
   logic                              div_start;

   ppw_pkg::state_type                state_ff, state_in;
   logic                              stop_ff, stop_in;
   logic [ppw_pkg::INDEX_W-1:0]       index_ff, index_in;
   logic                              last_ff, last_in;
   logic signed [ppw_pkg::WORD_W-1:0] x_ff, x_in;
   logic signed [ppw_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic                              flag_ff, flag_in;
   logic [1:0]                        stage_ff, stage_in;
   logic [65:0]                       prod_ff, prod_in;
   logic                              hneg_ff, hneg_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ppw_pkg::WORD_W-1:0] rsp_wl_ff, rsp_wl_in;
   logic                              rsp_flag_ff, rsp_flag_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              req_beat;
   logic                              rsp_free;
   logic                              out_load;
   logic signed [60:0]                scaled;
   logic signed [ppw_pkg::WORD_W-1:0] coef;
   logic [ppw_pkg::WORD_W-1:0]        acc_mag;
   logic signed [ppw_pkg::WORD_W-1:0] final_sum;

   ppw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ppw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (x_ff),
      .quotient (div_q),
      .status   (div_status)
   );

   // Handshake: take a pixel only when the sequencer is idle.
   assign req_stall = (state_ff != ppw_pkg::ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   // The output register can take a result when empty or draining this cycle.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ppw_pkg::ST_OUT) && rsp_free;
   assign div_start = (state_ff == ppw_pkg::ST_DIVS);

   // Reference coordinate product: 13-bit signed index times 48-bit scale.
   assign scaled = 61'($signed({1'b0, index_ff})) * 61'(cfg.pixel_scale);

   // Horner coefficient for the add that follows each division but the last.
   always_comb begin
      case (stage_ff)
         2'd0:    coef = cfg.inverse_term_three;
         2'd1:    coef = cfg.inverse_term_two;
         default: coef = cfg.inverse_term_one;
      endcase
   end

   assign acc_mag   = acc_ff[ppw_pkg::WORD_W-1] ? 48'd0 - acc_ff : acc_ff;
   assign final_sum = ppw_pkg::sat48(64'(cfg.base_wavelength) + 64'(acc_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppw_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = stop_ff ? ppw_pkg::ST_OUT : ppw_pkg::ST_MUL;
            end
         end
         ppw_pkg::ST_MUL:   state_in = ppw_pkg::ST_CHECK;
         ppw_pkg::ST_CHECK: begin
            state_in = (x_ff == '0) ? ppw_pkg::ST_HELIO : ppw_pkg::ST_DIVS;
         end
         ppw_pkg::ST_DIVS:  state_in = ppw_pkg::ST_DIVW;
         ppw_pkg::ST_DIVW: begin
            if (div_status.done) begin
               state_in = (stage_ff == 2'd3) ? ppw_pkg::ST_FINAL : ppw_pkg::ST_ADD;
            end
         end
         ppw_pkg::ST_ADD:   state_in = ppw_pkg::ST_DIVS;
         ppw_pkg::ST_FINAL: state_in = ppw_pkg::ST_HELIO;
         ppw_pkg::ST_HELIO: state_in = ppw_pkg::ST_HSAT;
         ppw_pkg::ST_HSAT:  state_in = ppw_pkg::ST_OUT;
         ppw_pkg::ST_OUT: begin
            if (rsp_free) begin
               state_in = ppw_pkg::ST_IDLE;
            end
         end
         default:           state_in = ppw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      stop_in     = stop_ff;
      index_in    = index_ff;
      last_in     = last_ff;
      x_in        = x_ff;
      acc_in      = acc_ff;
      flag_in     = flag_ff;
      stage_in    = stage_ff;
      prod_in     = prod_ff;
      hneg_in     = hneg_ff;
      rsp_wl_in   = rsp_wl_ff;
      rsp_flag_in = rsp_flag_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ppw_pkg::ST_IDLE: begin
            if (req_beat) begin
               index_in = req_pixel_index;
               last_in  = req_row_end;
               // latched row: clamp without the heliocentric factor
               flag_in  = stop_ff;
               acc_in   = ppw_pkg::MAX_WAVELENGTH;
            end
         end
         ppw_pkg::ST_MUL: begin
            x_in = ppw_pkg::sat48(64'(scaled) - 64'(cfg.pixel_origin));
         end
         ppw_pkg::ST_CHECK: begin
            stage_in = 2'd0;
            if (x_ff == '0) begin
               // zero divisor counts as beyond the maximum
               acc_in  = ppw_pkg::MAX_WAVELENGTH;
               flag_in = 1'b1;
            end else begin
               acc_in = cfg.inverse_term_four;
            end
         end
         ppw_pkg::ST_DIVS: begin
         end
         ppw_pkg::ST_DIVW: begin
            if (div_status.done) begin
               acc_in = div_q;
            end
         end
         ppw_pkg::ST_ADD: begin
            acc_in   = ppw_pkg::sat48(64'(coef) + 64'(acc_ff));
            stage_in = stage_ff + 2'd1;
         end
         ppw_pkg::ST_FINAL: begin
            if (final_sum > ppw_pkg::MAX_WAVELENGTH) begin
               acc_in  = ppw_pkg::MAX_WAVELENGTH;
               flag_in = 1'b1;
            end else begin
               acc_in = final_sum;
            end
         end
         ppw_pkg::ST_HELIO: begin
            prod_in = 66'(acc_mag) * 66'(cfg.helio_factor);
            hneg_in = acc_ff[ppw_pkg::WORD_W-1];
         end
         ppw_pkg::ST_HSAT: begin
            acc_in = ppw_pkg::mag_to_signed(prod_ff[65:ppw_pkg::FRAC_W], hneg_ff);
         end
         ppw_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_wl_in    = acc_ff;
               rsp_flag_in  = flag_ff;
               rsp_last_in  = last_ff;
               // latch on a clamp, release after the row's last pixel
               stop_in      = last_ff ? 1'b0 : (stop_ff || flag_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppw_pkg::ST_IDLE;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff    <= index_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      flag_ff     <= flag_in;
      stage_ff    <= stage_in;
      prod_ff     <= prod_in;
      hneg_ff     <= hneg_in;
      rsp_wl_ff   <= rsp_wl_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wavelength  = rsp_wl_ff;
   assign rsp_defect_flag = rsp_flag_ff;
   assign rsp_row_last    = rsp_last_ff;

   // The divider is never restarted while a division runs.
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppw_pkg::ST_DIVS) |-> !div_status.busy)
      else $error("divider started while busy");

   // A division result only arrives while the sequencer waits for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ppw_pkg::ST_DIVW))
      else $error("divider result outside wait state");

   // A pixel of a latched row goes straight to the output with the defect flag.
   a_latched_shortcut: assert property (@(posedge clock) disable iff (reset)
      (req_beat && stop_ff) |=> (state_ff == ppw_pkg::ST_OUT && flag_ff))
      else $error("latched row pixel not clamped directly");

   // The row's last beat releases the stop latch.
   a_row_end_release: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> !stop_ff)
      else $error("stop latch held past row end");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the prism pixel-to-wavelength block.
`timescale 1ns / 1ps

module tb;
   import ppw_pkg::*;

   // 48-bit signed bounds, held in 64-bit arithmetic
   localparam longint          WORD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint          WORD_MIN = -64'sh0000_8000_0000_0000;
   localparam longint unsigned POS_CAP  = 64'h0000_7FFF_FFFF_FFFF;
   localparam longint unsigned NEG_CAP  = 64'h0000_8000_0000_0000;
   localparam logic [WORD_W-1:0] TOP_WORD    = WORD_MAX[WORD_W-1:0];
   localparam logic [WORD_W-1:0] BOTTOM_WORD = WORD_MIN[WORD_W-1:0];
   localparam logic [HELIO_W-1:0] HELIO_ALL_ONES = '1;

   localparam int unsigned PIXEL_MAX        = (1 << INDEX_W) - 1;
   localparam int unsigned FIRST_UNUSED_REG = REG_HELIO_FACTOR + 1;
   localparam int unsigned LAST_REG_SLOT    = (1 << CSR_INDEX_W) - 1;
   // Quiet time after the queue drains; gives the tail a comfortable margin.
   localparam int unsigned SETTLE_CYCLES    = 300;
   localparam int unsigned HOLD_OFF_CYCLES  = 1500;
   localparam int unsigned REPORT_LIMIT     = 10;
   localparam int unsigned RANDOM_PHASES    = 12;
   localparam int unsigned PHASE_PIXELS     = 110;
   localparam int unsigned STEADY_PIXELS    = 150;

   typedef struct packed {
      logic [INDEX_W-1:0]       pixel;
      logic signed [WORD_W-1:0] wavelength;
      logic                     defect;
      logic                     row_last;
   } pixel_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [INDEX_W-1:0]           req_pixel_index = '0;
   logic                         req_row_end = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [WORD_W-1:0]     rsp_wavelength;
   logic                         rsp_defect_flag;
   logic                         rsp_row_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [WORD_W-1:0]            csr_data = '0;

   // Predictor state: our own copy of the registers and the row stop latch.
   cfg_type                      setup;
   bit                           row_stopped;
   pixel_result_type             wavelength_q[$];
   int unsigned                  mismatches = 0;

   // Traffic shaping shared by the sender, the receiver and the tests.
   bit                           calm = 1'b0;
   int unsigned                  idle_odds = 3;
   int unsigned                  hold_off_request = 0;
   int unsigned                  crossing_pixel = 0;

   prism_pixel_to_wavelength DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_index (req_pixel_index),
      .req_row_end     (req_row_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wavelength  (rsp_wavelength),
      .rsp_defect_flag (rsp_defect_flag),
      .rsp_row_last    (rsp_row_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #(40_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- arithmetic

   function automatic longint clip48(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint unsigned abs_value(input longint v);
      if (v < 0) return -v;
      return v;
   endfunction

   // Re-attach a sign to a magnitude, pinning it to the 48-bit range.
   function automatic longint apply_sign(input longint unsigned m, input bit neg);
      if (neg) begin
         if (m > NEG_CAP) m = NEG_CAP;
         return -longint'(m);
      end
      if (m > POS_CAP) m = POS_CAP;
      return longint'(m);
   endfunction

   // Q16 quotient (a << 16) / x, truncated toward zero; x is never zero here.
   function automatic longint div_q16(input longint a, input longint x);
      longint unsigned num;
      longint unsigned quo;
      num = abs_value(a) << FRAC_W;
      quo = num / abs_value(x);
      return apply_sign(quo, (a < 0) != (x < 0));
   endfunction

   // Heliocentric product wl * h / 2^16 split into integer and fraction parts.
   function automatic longint scale_helio(input longint wl);
      longint unsigned m;
      longint unsigned h;
      longint unsigned prod;
      m    = abs_value(wl);
      h    = 64'(setup.helio_factor);
      prod = (m >> FRAC_W) * h + (((m & 64'hFFFF) * h) >> FRAC_W);
      return apply_sign(prod, wl < 0);
   endfunction

   // Expected result of one pixel beat; advances the row stop latch.
   function automatic pixel_result_type compute_wavelength(input logic [INDEX_W-1:0] idx,
                                                           input logic last);
      pixel_result_type r;
      longint           x;
      longint           wl;
      bit               over;
      bit               flagged;
      flagged = 1'b0;
      if (row_stopped) begin
         // Latched row: pin to the maximum, no heliocentric factor.
         wl      = longint'(MAX_WAVELENGTH);
         flagged = 1'b1;
      end else begin
         x = clip48(longint'(idx) * longint'($signed(setup.pixel_scale))
                    - longint'($signed(setup.pixel_origin)));
         if (x == 0) begin
            // Zero divisor counts as beyond the maximum.
            over = 1'b1;
            wl   = 0;
         end else begin
            // Horner in 1/x; saturated partial sums pass through unflagged.
            wl   = div_q16(longint'($signed(setup.inverse_term_four)), x);
            wl   = div_q16(clip48(longint'($signed(setup.inverse_term_three)) + wl), x);
            wl   = div_q16(clip48(longint'($signed(setup.inverse_term_two)) + wl), x);
            wl   = div_q16(clip48(longint'($signed(setup.inverse_term_one)) + wl), x);
            wl   = clip48(longint'($signed(setup.base_wavelength)) + wl);
            over = wl > longint'(MAX_WAVELENGTH);
         end
         if (over) begin
            wl          = longint'(MAX_WAVELENGTH);
            flagged     = 1'b1;
            row_stopped = 1'b1;
         end
         wl = scale_helio(wl);
      end
      if (last) row_stopped = 1'b0;
      r.pixel      = idx;
      r.wavelength = wl[WORD_W-1:0];
      r.defect     = flagged;
      r.row_last   = last;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   // Compare every accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (wavelength_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat: wavelength %0d defect %0b last %0b",
                        rsp_wavelength, rsp_defect_flag, rsp_row_last);
         end else begin
            want = wavelength_q.pop_front();
            if (rsp_wavelength !== want.wavelength || rsp_defect_flag !== want.defect ||
                rsp_row_last !== want.row_last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch pixel %0d: wavelength exp %0d got %0d, ",
                           want.pixel, want.wavelength, rsp_wavelength,
                           "defect exp %0b got %0b, last exp %0b got %0b",
                           want.defect, rsp_defect_flag, want.row_last, rsp_row_last);
            end
         end
      end
   end

   // Receiver: random stall bursts, or one long hold-off when a test asks.
   initial begin : receiver_side
      int unsigned span;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            span             = hold_off_request;
            hold_off_request = 0;
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && idle_odds != 0 && $urandom_range(1, 16) <= idle_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Offer one pixel beat, hold it until accepted, then log its prediction.
   task automatic send_pixel(input logic [INDEX_W-1:0] idx, input logic last);
      if (!calm && idle_odds != 0 && $urandom_range(1, 8) <= idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_index <= idx;
      req_row_end     <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      wavelength_q.push_back(compute_wavelength(idx, last));
   endtask

   // Write one register, then wait with csr_valid low so back-to-back writes never
   // lower and raise csr_valid in the same step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] slot, input logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= slot;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (slot)
         REG_PIXEL_SCALE:        setup.pixel_scale        = value;
         REG_PIXEL_ORIGIN:       setup.pixel_origin       = value;
         REG_BASE_WAVELENGTH:    setup.base_wavelength    = value;
         REG_INVERSE_TERM_ONE:   setup.inverse_term_one   = value;
         REG_INVERSE_TERM_TWO:   setup.inverse_term_two   = value;
         REG_INVERSE_TERM_THREE: setup.inverse_term_three = value;
         REG_INVERSE_TERM_FOUR:  setup.inverse_term_four  = value;
         REG_HELIO_FACTOR:       setup.helio_factor       = value[HELIO_W-1:0];
         default: ;  // unused slots are dropped by the block
      endcase
      @(posedge clock);
   endtask

   // Drop valid, drain every outstanding result, then let the pipe go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (wavelength_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_row(input logic [INDEX_W-1:0] start, input int unsigned step,
                           input int unsigned count, input bit close);
      logic [INDEX_W-1:0] pix;
      for (int unsigned k = 0; k < count; k++) begin
         pix = INDEX_W'(32'(start) + k * step);
         send_pixel(pix, close && (k == count - 1));
      end
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[WORD_W-1:0];
   endfunction

   function automatic longint random_sign();
      return ($urandom_range(0, 1) == 1) ? -64'sd1 : 64'sd1;
   endfunction

   // Plausible dispersion: the zero of x falls at or less than two pixels past
   // crossing_pixel, so rows that walk across it hit the clamp and latch mid-row.
   task automatic load_prism_setup();
      longint scale;
      longint origin;
      scale          = longint'($urandom_range(32768, 262144));
      crossing_pixel = $urandom_range(0, PIXEL_MAX);
      origin         = longint'(crossing_pixel) * scale + longint'($urandom_range(0, 65535));
      write_reg(REG_PIXEL_SCALE, scale[WORD_W-1:0]);
      write_reg(REG_PIXEL_ORIGIN, origin[WORD_W-1:0]);
      write_reg(REG_BASE_WAVELENGTH,
                WORD_W'(longint'($urandom_range(1000, 6000)) << FRAC_W));
      write_reg(REG_INVERSE_TERM_ONE,
                WORD_W'(longint'($urandom_range(0, 8_000_000)) << FRAC_W));
      write_reg(REG_INVERSE_TERM_TWO, WORD_W'(longint'($urandom()) * random_sign()));
      write_reg(REG_INVERSE_TERM_THREE,
                WORD_W'(longint'($urandom_range(0, 32'h00FF_FFFF)) * random_sign()));
      write_reg(REG_INVERSE_TERM_FOUR,
                WORD_W'(longint'($urandom_range(0, 32'h000F_FFFF)) * random_sign()));
      write_reg(REG_HELIO_FACTOR,
                WORD_W'($urandom_range(int'(HELIO_UNITY) - 2000, int'(HELIO_UNITY) + 2000)));
   endtask

   // Full-width noise in every register, with a stray write to an unused slot.
   task automatic load_random_setup();
      for (int unsigned slot = REG_PIXEL_SCALE; slot <= REG_HELIO_FACTOR; slot++)
         write_reg(CSR_INDEX_W'(slot), random_word());
      write_reg(CSR_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_SLOT)), random_word());
   endtask

   // ---------------------------------------------------------------- tests

   // Reset values: pixel 0 divides by zero, clamps and latches the row.
   task automatic test_reset_defaults();
      send_pixel('0, 1'b0);
      send_pixel(INDEX_W'(PIXEL_MAX), 1'b0);
      send_pixel(12'd1, 1'b1);
      send_pixel(INDEX_W'(PIXEL_MAX), 1'b1);
      send_pixel('0, 1'b1);
      settle();
   endtask

   // A fixed prism row that crosses the origin: first clamp, latched tail,
   // row end clearing the latch, then an exact zero divisor.
   task automatic test_prism_row();
      write_reg(REG_PIXEL_SCALE, 48'sd65536);
      write_reg(REG_PIXEL_ORIGIN, 48'sd13_107_200);
      write_reg(REG_BASE_WAVELENGTH, 48'sd196_608_000);
      write_reg(REG_INVERSE_TERM_ONE, 48'sd26_214_400_000);
      write_reg(REG_INVERSE_TERM_TWO, -48'sd65_536_000_000);
      write_reg(REG_INVERSE_TERM_THREE, 48'sd5_000_000);
      write_reg(REG_INVERSE_TERM_FOUR, -48'sd1_000_000);
      write_reg(REG_HELIO_FACTOR, WORD_W'(HELIO_UNITY) + 48'd300);
      send_pixel(12'd150, 1'b0);
      send_pixel(12'd199, 1'b0);
      send_pixel(12'd201, 1'b0);
      send_pixel(12'd210, 1'b0);
      send_pixel(12'd4000, 1'b1);
      send_pixel(12'd260, 1'b0);
      send_pixel(12'd1000, 1'b1);
      send_pixel(12'd200, 1'b1);
      settle();
   endtask

   // Register extremes, helio outside its nominal range, and saturating
   // partial sums that must not raise the defect flag on their own.
   task automatic test_word_extremes();
      write_reg(REG_PIXEL_SCALE, BOTTOM_WORD);
      write_reg(REG_PIXEL_ORIGIN, TOP_WORD);
      write_reg(REG_BASE_WAVELENGTH, BOTTOM_WORD);
      write_reg(REG_INVERSE_TERM_ONE, TOP_WORD);
      write_reg(REG_INVERSE_TERM_TWO, TOP_WORD);
      write_reg(REG_INVERSE_TERM_THREE, TOP_WORD);
      write_reg(REG_INVERSE_TERM_FOUR, TOP_WORD);
      write_reg(REG_HELIO_FACTOR, WORD_W'(HELIO_ALL_ONES));
      send_pixel(INDEX_W'(PIXEL_MAX), 1'b0);
      send_pixel('0, 1'b0);
      send_pixel(12'd1, 1'b1);
      settle();

      write_reg(REG_PIXEL_SCALE, TOP_WORD);
      write_reg(REG_PIXEL_ORIGIN, BOTTOM_WORD);
      write_reg(REG_BASE_WAVELENGTH, TOP_WORD);
      write_reg(REG_INVERSE_TERM_ONE, BOTTOM_WORD);
      write_reg(REG_INVERSE_TERM_TWO, BOTTOM_WORD);
      write_reg(REG_INVERSE_TERM_THREE, BOTTOM_WORD);
      write_reg(REG_INVERSE_TERM_FOUR, BOTTOM_WORD);
      write_reg(REG_HELIO_FACTOR, '0);
      send_pixel(INDEX_W'(PIXEL_MAX), 1'b0);
      send_pixel('0, 1'b1);
      settle();

      // Tiny x makes every quotient saturate; the minimum base pulls the sum
      // back below the maximum.
      write_reg(REG_PIXEL_SCALE, 48'd1);
      write_reg(REG_PIXEL_ORIGIN, '0);
      write_reg(REG_BASE_WAVELENGTH, BOTTOM_WORD);
      write_reg(REG_INVERSE_TERM_ONE, TOP_WORD);
      write_reg(REG_INVERSE_TERM_TWO, TOP_WORD);
      write_reg(REG_INVERSE_TERM_THREE, TOP_WORD);
      write_reg(REG_INVERSE_TERM_FOUR, TOP_WORD);
      write_reg(REG_HELIO_FACTOR, WORD_W'(HELIO_UNITY));
      send_pixel(12'd3, 1'b0);
      send_pixel(INDEX_W'(PIXEL_MAX), 1'b1);
      settle();
   endtask

   // A write to a slot past the last register must leave the setup alone.
   task automatic test_ignored_index();
      write_reg(CSR_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_SLOT)), random_word());
      send_pixel(12'd5, 1'b1);
      settle();
   endtask

   // Mostly well-formed rows with random content, some rows left open, some
   // lone pixels with random row_end.
   task automatic test_random_rows();
      int unsigned sent;
      int unsigned pick;
      int unsigned count;
      int unsigned start;
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_odds = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0)
            load_random_setup();
         else
            load_prism_setup();
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               if ($urandom_range(0, 1) == 1)
                  start = crossing_pixel - $urandom_range(0, 40);
               else
                  start = $urandom_range(0, PIXEL_MAX);
               count = $urandom_range(1, 24);
               send_row(INDEX_W'(start), $urandom_range(1, 16), count, pick != 0);
               sent += count;
            end else begin
               send_pixel(INDEX_W'($urandom_range(0, PIXEL_MAX)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         settle();
      end
   endtask

   // Hold the result side off long enough that the output register and the
   // pixel in work both fill and req_stall backs up the sender.
   task automatic test_backpressure();
      idle_odds = 2;
      load_prism_setup();
      hold_off_request = HOLD_OFF_CYCLES;
      send_row(INDEX_W'(crossing_pixel + 10), 3, 8, 1'b1);
      settle();
   endtask

   // Closing stretch with no idling on either side.
   task automatic test_steady_stream();
      int unsigned sent;
      int unsigned count;
      calm = 1'b1;
      load_prism_setup();
      sent = 0;
      while (sent < STEADY_PIXELS) begin
         count = $urandom_range(1, 24);
         send_row(INDEX_W'(crossing_pixel - $urandom_range(0, 30)), $urandom_range(1, 8),
                  count, 1'b1);
         sent += count;
      end
      settle();
   endtask

   initial begin
      // Mirror the block's reset values.
      setup.pixel_scale        = SCALE_RESET;
      setup.pixel_origin       = '0;
      setup.base_wavelength    = '0;
      setup.inverse_term_one   = '0;
      setup.inverse_term_two   = '0;
      setup.inverse_term_three = '0;
      setup.inverse_term_four  = '0;
      setup.helio_factor       = HELIO_UNITY;
      row_stopped              = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_prism_row();
      test_word_extremes();
      test_ignored_index();
      test_random_rows();
      test_backpressure();
      test_steady_stream();

      if (mismatches == 0 && wavelength_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
